[design/open_addressing_id_set_assert.svh]
// Assertion macros for the id set block
`ifndef OPEN_ADDRESSING_ID_SET_ASSERT_SVH
`define OPEN_ADDRESSING_ID_SET_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define OAIS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define OAIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[design/oais_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oais_pkg
// Shared constants and codes for the open addressing id set.
// ----------------------------------------------------------------------------
package oais_pkg;
    localparam logic [31:0] HASH_MULT = 32'd2654435761;
    localparam logic [31:0] INVALID_ID = 32'hFFFF_FFFF;

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_DELETE  = 2'd1;
    localparam logic [1:0] FUNC_LIST    = 2'd2;
    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_PRESENT  = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_ABSENT   = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_INVALID  = 3'd5;
    localparam logic [2:0] ST_MEMBER   = 3'd6;
    localparam logic [2:0] ST_EMPTY    = 3'd7;
endpackage

[design/oais_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oais_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module oais_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[design/oais_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oais_hash
// Registered multiplicative hash: home slot of a stored key.
// ----------------------------------------------------------------------------
module oais_hash #(
    parameter int AW = 6
) (
    input  logic          clk,
    input  logic [31:0]   key,
    output logic [AW-1:0] slot
);
    logic [31:0] prod;

    assign prod = key * oais_pkg::HASH_MULT;

    always_ff @(posedge clk)
    begin
        slot <= prod[AW-1:0];
    end
endmodule

[design/open_addressing_id_set.sv]
`timescale 1ns / 1ps
// After accept, insert hashes, then reads and checks each probed slot and writes if it
// inserts; delete does the same without a write; invalid id and empty list answer next
// cycle. An insert at half occupancy first rehashes each live key into the shadow RAM
// and copies it back. List reads and checks each slot scanned and waits at each output.
// One request at a time; the probe loop through the single-port key RAM sets the rate.
// Reset (rst_n low, asynchronous) empties the set at once through per-slot valid bits.
// ----------------------------------------------------------------------------
// open_addressing_id_set
// Set of 32-bit ids in a linear-probing hash table with tombstones.
// ----------------------------------------------------------------------------
module open_addressing_id_set #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // func[1:0], entity_id[33:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status[2:0], member_id[34:3], live_count[41:35], pad
    output logic        m_tlast
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] HALF = CW'(CAPACITY / 2);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_HASH   = 14'b00000000000010,
        S_RD     = 14'b00000000000100,
        S_CHK    = 14'b00000000001000,
        S_WR     = 14'b00000000010000,
        S_OUT    = 14'b00000000100000,
        S_LRD    = 14'b00000001000000,
        S_LCHK   = 14'b00000010000000,
        S_CSCAN  = 14'b00000100000000,
        S_CCHK   = 14'b00001000000000,
        S_CHASH  = 14'b00010000000000,
        S_CPRB   = 14'b00100000000000,
        S_CPCHK  = 14'b01000000000000,
        S_CCOPY  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]  func_reg;
    logic [31:0] key_reg;            // stored key = id + 1
    logic [AW-1:0] j_reg;            // probe slot
    logic [CW-1:0] n_reg;            // probe count
    logic [AW:0]   i_reg;            // scan index
    logic [AW-1:0] hole_reg;
    logic          hole_ok_reg;
    logic [CW-1:0] live_reg, occ_reg;
    logic [CW-1:0] seen_reg;
    logic [CAPACITY-1:0] valid_reg, tomb_reg, sh_valid_reg;
    logic [2:0]  st_reg;
    logic [31:0] mem_out_reg;
    logic        last_reg;
    logic        cp_phase_reg;       // copy: 0 read shadow, 1 write main

    // main key RAM and shadow RAM
    logic          k_we, s_we;
    logic [AW-1:0] k_addr, s_addr;
    logic [31:0]   k_wdata, k_rdata, s_wdata, s_rdata;
    logic [AW-1:0] home;
    logic [31:0]   hash_in;

    oais_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_keys (
        .clk(clk), .we(k_we), .addr(k_addr), .wdata(k_wdata), .rdata(k_rdata));
    oais_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_shadow (
        .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));
    oais_hash #(.AW(AW)) u_hash (.clk(clk), .key(hash_in), .slot(home));

    logic [AW-1:0] i_lo;
    logic          in_ok, m_ok;
    logic [31:0]   in_id;
    logic          slot_v, slot_t, live_hit;
    assign i_lo   = i_reg[AW-1:0];
    assign in_ok  = s_tvalid && s_tready;
    assign m_ok   = m_tvalid && m_tready;
    assign in_id  = s_tdata[33:2];
    assign slot_v = valid_reg[j_reg];
    assign slot_t = tomb_reg[j_reg];
    assign live_hit = slot_v && !slot_t && (k_rdata == key_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tlast  = last_reg;
    assign m_tdata  = {6'd0, 7'(live_reg), mem_out_reg, st_reg};
    // hash in the preceding state so home is ready when the slot is loaded
    assign hash_in  = (state_reg == S_CCHK) ? k_rdata
                    : (state_reg == S_IDLE) ? in_id + 32'd1 : key_reg;

    always_comb
    begin
        k_we = 1'b0; k_addr = j_reg; k_wdata = key_reg;
        s_we = 1'b0; s_addr = j_reg; s_wdata = mem_out_reg;
        case (state_reg)
            S_WR:    k_we = 1'b1;
            S_LRD, S_CSCAN: k_addr = i_lo;
            S_CPRB:  s_addr = j_reg;
            S_CPCHK: s_we = !sh_valid_reg[j_reg];
            S_CCOPY:
            begin
                s_addr = i_lo; k_addr = i_lo; k_wdata = s_rdata;
                k_we = cp_phase_reg && sh_valid_reg[i_lo];
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_ok)
                begin
                    if (s_tdata[1:0] == oais_pkg::FUNC_LIST)
                        state_next = (live_reg == '0) ? S_OUT : S_LRD;
                    else if (s_tdata[1:0] == oais_pkg::FUNC_UNKNOWN)
                        state_next = S_IDLE;
                    else if (in_id == oais_pkg::INVALID_ID)
                        state_next = S_OUT;
                    else if (s_tdata[1:0] == oais_pkg::FUNC_INSERT && occ_reg >= HALF)
                        state_next = S_CSCAN;
                    else
                        state_next = S_HASH;
                end
            S_HASH:  state_next = S_RD;
            S_RD:    state_next = S_CHK;
            S_CHK:
                if (n_reg < CW'(CAPACITY) && slot_v)
                begin
                    if (live_hit) state_next = S_OUT;
                    else state_next = S_RD;
                end
                else if (func_reg == oais_pkg::FUNC_DELETE) state_next = S_OUT;
                else if (live_reg >= HALF) state_next = S_OUT;
                else if (!hole_ok_reg && slot_v) state_next = S_OUT;
                else state_next = S_WR;
            S_WR:    state_next = S_OUT;
            S_OUT:
                if (m_ok)
                    state_next = (func_reg == oais_pkg::FUNC_LIST && !last_reg)
                                 ? S_LRD : S_IDLE;
            S_LRD:   state_next = S_LCHK;
            S_LCHK:
                if (valid_reg[i_lo] && !tomb_reg[i_lo]) state_next = S_OUT;
                else state_next = S_LRD;
            S_CSCAN: state_next = S_CCHK;
            S_CCHK:
                if (i_reg == (AW+1)'(CAPACITY)) state_next = S_CCOPY;
                else if (valid_reg[i_lo] && !tomb_reg[i_lo]) state_next = S_CHASH;
                else state_next = S_CSCAN;
            S_CHASH: state_next = S_CPRB;
            S_CPRB:  state_next = S_CPCHK;
            S_CPCHK:
                if (!sh_valid_reg[j_reg] || n_reg >= CW'(CAPACITY - 1))
                    state_next = S_CSCAN;
                else
                    state_next = S_CPRB;
            S_CCOPY:
                if (cp_phase_reg && i_reg == (AW+1)'(CAPACITY - 1)) state_next = S_HASH;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            tomb_reg <= '0;
            sh_valid_reg <= '0;
            live_reg <= '0;
            occ_reg <= '0;
            cp_phase_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                    if (in_ok)
                    begin
                        func_reg <= s_tdata[1:0];
                        key_reg <= in_id + 32'd1;
                        hole_ok_reg <= 1'b0;
                        mem_out_reg <= '0;
                        last_reg <= 1'b1;
                        i_reg <= '0;
                        seen_reg <= '0;
                        sh_valid_reg <= '0;
                        cp_phase_reg <= 1'b0;
                        st_reg <= (s_tdata[1:0] == oais_pkg::FUNC_LIST)
                                  ? oais_pkg::ST_EMPTY : oais_pkg::ST_INVALID;
                    end
                S_HASH:
                begin
                    j_reg <= home;
                    n_reg <= '0;
                end
                S_CHK:
                    if (n_reg < CW'(CAPACITY) && slot_v)
                    begin
                        if (live_hit)
                        begin
                            if (func_reg == oais_pkg::FUNC_DELETE)
                            begin
                                tomb_reg[j_reg] <= 1'b1;
                                live_reg <= live_reg - 1'b1;
                                st_reg <= oais_pkg::ST_REMOVED;
                            end
                            else
                                st_reg <= oais_pkg::ST_PRESENT;
                        end
                        else
                        begin
                            if (slot_t && !hole_ok_reg)
                            begin
                                hole_reg <= j_reg;
                                hole_ok_reg <= 1'b1;
                            end
                            j_reg <= j_reg + 1'b1;
                            n_reg <= n_reg + 1'b1;
                        end
                    end
                    else if (func_reg == oais_pkg::FUNC_DELETE)
                        st_reg <= oais_pkg::ST_ABSENT;
                    else if (live_reg >= HALF || (!hole_ok_reg && slot_v))
                        st_reg <= oais_pkg::ST_FULL;
                    else
                    begin
                        if (hole_ok_reg) j_reg <= hole_reg;
                        else occ_reg <= occ_reg + 1'b1;
                        live_reg <= live_reg + 1'b1;
                        st_reg <= oais_pkg::ST_INSERTED;
                    end
                S_WR:
                begin
                    valid_reg[j_reg] <= 1'b1;
                    tomb_reg[j_reg] <= 1'b0;
                end
                S_LCHK:
                begin
                    i_reg <= i_reg + 1'b1;
                    if (valid_reg[i_lo] && !tomb_reg[i_lo])
                    begin
                        seen_reg <= seen_reg + 1'b1;
                        st_reg <= oais_pkg::ST_MEMBER;
                        mem_out_reg <= k_rdata - 32'd1;
                        last_reg <= (seen_reg + 1'b1 == live_reg);
                    end
                end
                S_CCHK:
                    if (i_reg != (AW+1)'(CAPACITY))
                    begin
                        mem_out_reg <= k_rdata;
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                        i_reg <= '0;
                S_CHASH:
                begin
                    j_reg <= home;
                    n_reg <= '0;
                end
                S_CPCHK:
                    if (!sh_valid_reg[j_reg])
                        sh_valid_reg[j_reg] <= 1'b1;
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                        n_reg <= n_reg + 1'b1;
                    end
                S_CCOPY:
                begin
                    cp_phase_reg <= !cp_phase_reg;
                    if (cp_phase_reg)
                    begin
                        valid_reg[i_lo] <= sh_valid_reg[i_lo];
                        tomb_reg[i_lo] <= 1'b0;
                        i_reg <= i_reg + 1'b1;
                        if (i_reg == (AW+1)'(CAPACITY - 1))
                        begin
                            occ_reg <= live_reg;
                            mem_out_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `include "open_addressing_id_set_assert.svh"

    `OAIS_ASSERT_IMP(a_live_le_occ, 1'b1, live_reg <= occ_reg, "live exceeds occupied")
    `OAIS_ASSERT_IMP(a_occ_bound, 1'b1, occ_reg <= HALF, "occupied beyond half")
    `OAIS_ASSERT_NEXT(a_busy_after_accept, in_ok && s_tdata[1:0] != oais_pkg::FUNC_UNKNOWN,
                      !s_tready, "ready while busy")
    `OAIS_ASSERT_IMP(a_member_nonzero, m_tvalid && st_reg != oais_pkg::ST_MEMBER,
                     mem_out_reg == '0, "member id set on non-member status")
endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the id set against a behavioral copy of the hash table: directed
// corner requests, fill and rebuild, then random requests under back-pressure.
// ----------------------------------------------------------------------------
module tb;
    localparam int CAP = 64;
    localparam int HALF = CAP / 2;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] member_id;
        logic [6:0]  live_count;
        logic        last;
    } set_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    open_addressing_id_set #(.CAPACITY(CAP)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #4 clk = ~clk;

    // behavioral table
    logic [31:0] tbl_key [CAP];
    logic        tbl_tomb [CAP];
    int          n_live;
    int          n_occupied;
    set_result_t pending_results[$];

    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;
    int mismatches;
    int quiet_cycles;

    function automatic int home_of(logic [31:0] stored);
        logic [31:0] h;
        h = stored * oais_pkg::HASH_MULT;
        return int'(h % CAP);
    endfunction

    function automatic void rebuild_table();
        logic [31:0] shadow [CAP];
        int j;
        int n;
        for (int i = 0; i < CAP; i++) shadow[i] = '0;
        for (int i = 0; i < CAP; i++) begin
            if (tbl_key[i] != 0 && !tbl_tomb[i]) begin
                j = home_of(tbl_key[i]);
                for (n = 0; n < CAP && shadow[j] != 0; n++) j = (j + 1) % CAP;
                if (shadow[j] == 0) shadow[j] = tbl_key[i];
            end
        end
        for (int i = 0; i < CAP; i++) begin
            tbl_key[i] = shadow[i];
            tbl_tomb[i] = 1'b0;
        end
        n_occupied = n_live;
    endfunction

    function automatic logic [2:0] insert_id(logic [31:0] id);
        logic [31:0] stored;
        int j;
        int hole;
        bit have_hole;
        stored = id + 1;
        hole = 0;
        have_hole = 0;
        if (n_occupied >= HALF) rebuild_table();
        j = home_of(stored);
        for (int n = 0; n < CAP && tbl_key[j] != 0; n++) begin
            if (tbl_key[j] == stored && !tbl_tomb[j]) return oais_pkg::ST_PRESENT;
            if (tbl_tomb[j] && !have_hole) begin
                hole = j;
                have_hole = 1;
            end
            j = (j + 1) % CAP;
        end
        if (n_live >= HALF) return oais_pkg::ST_FULL;
        if (have_hole) j = hole;
        else if (tbl_key[j] != 0) return oais_pkg::ST_FULL;
        tbl_key[j] = stored;
        tbl_tomb[j] = 1'b0;
        n_live++;
        if (!have_hole) n_occupied++;
        return oais_pkg::ST_INSERTED;
    endfunction

    function automatic logic [2:0] delete_id(logic [31:0] id);
        logic [31:0] stored;
        int j;
        stored = id + 1;
        j = home_of(stored);
        for (int n = 0; n < CAP && tbl_key[j] != 0; n++) begin
            if (tbl_key[j] == stored && !tbl_tomb[j]) begin
                tbl_tomb[j] = 1'b1;
                n_live--;
                return oais_pkg::ST_REMOVED;
            end
            j = (j + 1) % CAP;
        end
        return oais_pkg::ST_ABSENT;
    endfunction

    function automatic void push_result(logic [2:0] st, logic [31:0] mid, bit lst);
        set_result_t r;
        r.status = st;
        r.member_id = mid;
        r.live_count = n_live[6:0];
        r.last = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_request(logic [1:0] func, logic [31:0] id);
        int seen;
        if (func == oais_pkg::FUNC_INSERT || func == oais_pkg::FUNC_DELETE) begin
            if (id == oais_pkg::INVALID_ID) push_result(oais_pkg::ST_INVALID, '0, 1);
            else if (func == oais_pkg::FUNC_INSERT) push_result(insert_id(id), '0, 1);
            else push_result(delete_id(id), '0, 1);
        end else if (func == oais_pkg::FUNC_LIST) begin
            if (n_live == 0) push_result(oais_pkg::ST_EMPTY, '0, 1);
            else begin
                seen = 0;
                for (int i = 0; i < CAP; i++) begin
                    if (tbl_key[i] != 0 && !tbl_tomb[i]) begin
                        seen++;
                        push_result(oais_pkg::ST_MEMBER, tbl_key[i] - 1, seen == n_live);
                    end
                end
            end
        end
    endfunction

    task automatic send_request(logic [1:0] func, logic [31:0] id);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        s_tdata = {6'b0, id, func};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_request(func, id);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    // receiver side
    always @(negedge clk) begin
        if (!rst_n || recv_hold) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        set_result_t got;
        set_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.status = m_tdata[2:0];
            got.member_id = m_tdata[34:3];
            got.live_count = m_tdata[41:35];
            got.last = m_tlast;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] tbl_pick_live();
        int start;
        start = $urandom_range(CAP - 1);
        for (int k = 0; k < CAP; k++) begin
            if (tbl_key[(start + k) % CAP] != 0 && !tbl_tomb[(start + k) % CAP])
                return tbl_key[(start + k) % CAP] - 1;
        end
        return $urandom();
    endfunction

    // extremes, invalid id, unknown op, empty list, duplicate, absent delete
    task automatic test_directed();
        send_request(oais_pkg::FUNC_LIST, '0);
        send_request(oais_pkg::FUNC_INSERT, 32'h0);
        send_request(oais_pkg::FUNC_INSERT, 32'h0);
        send_request(oais_pkg::FUNC_INSERT, 32'hFFFF_FFFE);
        send_request(oais_pkg::FUNC_INSERT, oais_pkg::INVALID_ID);
        send_request(oais_pkg::FUNC_DELETE, oais_pkg::INVALID_ID);
        send_request(oais_pkg::FUNC_UNKNOWN, 32'h1234_5678);
        send_request(oais_pkg::FUNC_DELETE, 32'h5555_AAAA);
        send_request(oais_pkg::FUNC_LIST, 32'hFFFF_FFFF);
        send_request(oais_pkg::FUNC_DELETE, 32'h0);
        send_request(oais_pkg::FUNC_INSERT, 32'h0);
        send_request(oais_pkg::FUNC_DELETE, 32'hFFFF_FFFE);
        send_request(oais_pkg::FUNC_DELETE, 32'h0);
        send_request(oais_pkg::FUNC_LIST, '0);
        wait_drained();
    endtask

    // fill to the limit, then push past it for full, rebuild, and a long list
    task automatic test_fill_and_rebuild();
        for (int i = 0; i < HALF + 4; i++) send_request(oais_pkg::FUNC_INSERT, $urandom());
        send_request(oais_pkg::FUNC_LIST, '0);
        for (int i = 0; i < 6; i++) send_request(oais_pkg::FUNC_DELETE, tbl_pick_live());
        for (int i = 0; i < 8; i++) send_request(oais_pkg::FUNC_INSERT, $urandom_range(200));
        send_request(oais_pkg::FUNC_LIST, '0);
        wait_drained();
    endtask

    // mostly small ids so duplicates and deletes hit; some full-range noise
    task automatic test_random(int count);
        int pick;
        logic [31:0] id;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            id = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(60);
            if (pick < 45) send_request(oais_pkg::FUNC_INSERT, id);
            else if (pick < 65) send_request(oais_pkg::FUNC_DELETE, id);
            else if (pick < 80) send_request(oais_pkg::FUNC_DELETE, tbl_pick_live());
            else if (pick < 90) send_request(oais_pkg::FUNC_LIST, $urandom());
            else if (pick < 95) send_request(oais_pkg::FUNC_UNKNOWN, $urandom());
            else send_request(2'($urandom_range(1)), oais_pkg::INVALID_ID);
        end
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        recv_hold = 1'b1;
        fork
            begin
                repeat (400) @(negedge clk);
                recv_hold = 1'b0;
            end
            for (int i = 0; i < 6; i++) send_request(oais_pkg::FUNC_LIST, '0);
        join
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < CAP; i++) begin
            tbl_key[i] = '0;
            tbl_tomb[i] = 1'b0;
        end
        n_live = 0;
        n_occupied = 0;
        mismatches = 0;
        quiet_cycles = 0;
        recv_hold = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 88;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_fill_and_rebuild();
        test_random(30);
        wait_drained();
        send_idle_pct = 88;
        recv_idle_pct = 28;
        test_random(20);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(30);
        wait_drained();
        if (mismatches == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule

[files.f]
+incdir+design
design/oais_pkg.sv
design/oais_ram.sv
design/oais_hash.sv
design/open_addressing_id_set.sv
bench/tb.sv
